// ===== rtl/tsqc_pkg.sv =====
// Shared types and constants for the thick segment quad cull block.
// Used by the top level, classifier and back-end sequencer; no dependencies.
package tsqc_pkg;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VIEW_MIN_X    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VIEW_MIN_Y    = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VIEW_MAX_X    = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VIEW_MAX_Y    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FLOOR_FILTER  = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FLOOR_SELECT  = 3'd5;

   localparam int FLOOR_WIDTH = 16;
   localparam int TAG_WIDTH   = 32;
   // Largest magnitude bit count of a direction component after normalizing.
   localparam int NORM_BITS   = 31;
   localparam int MUL_WIDTH   = 32;

   localparam logic [1:0] CORNER_LAST = 2'd3;

   // Classification that the front end attaches to each queued segment.
   typedef struct packed {
      logic new_scene;
      logic keep;
   } seg_ctl_type;

endpackage

// ===== rtl/tsqc_front.sv =====
// Front-end classifier: floor filter, padded view-box test, zero-length check.
// Depends on tsqc_pkg for the floor width.
module tsqc_front #(
   parameter int CW = 32,
   parameter int TW = 20
) (
   input  logic signed [CW-1:0]                  start_x,
   input  logic signed [CW-1:0]                  start_y,
   input  logic signed [CW-1:0]                  end_x,
   input  logic signed [CW-1:0]                  end_y,
   input  logic [TW-1:0]                         thickness,
   input  logic [tsqc_pkg::FLOOR_WIDTH-1:0]      floor_num,
   input  logic signed [CW-1:0]                  view_min_x,
   input  logic signed [CW-1:0]                  view_min_y,
   input  logic signed [CW-1:0]                  view_max_x,
   input  logic signed [CW-1:0]                  view_max_y,
   input  logic                                  floor_filter_on,
   input  logic [tsqc_pkg::FLOOR_WIDTH-1:0]      floor_select,
   output logic                                  keep
);

   localparam int BW = ((CW > TW) ? CW : TW) + 3;

   logic signed [CW-1:0] lo_x, hi_x, lo_y, hi_y;
   logic signed [BW-1:0] t_e;
   logic signed [BW-1:0] lo2_x, hi2_x, lo2_y, hi2_y;
   logic signed [BW-1:0] vmin2_x, vmin2_y, vmax2_x, vmax2_y;
   logic floor_ok, box_ok, len_ok;

   always_comb begin
      lo_x = (start_x < end_x) ? start_x : end_x;
      hi_x = (start_x > end_x) ? start_x : end_x;
      lo_y = (start_y < end_y) ? start_y : end_y;
      hi_y = (start_y > end_y) ? start_y : end_y;
      t_e  = $signed(BW'(thickness));
      // Doubled coordinates keep half the thickness exact.
      lo2_x = (BW'(lo_x) <<< 1) - t_e;
      hi2_x = (BW'(hi_x) <<< 1) + t_e;
      lo2_y = (BW'(lo_y) <<< 1) - t_e;
      hi2_y = (BW'(hi_y) <<< 1) + t_e;
      vmin2_x = BW'(view_min_x) <<< 1;
      vmin2_y = BW'(view_min_y) <<< 1;
      vmax2_x = BW'(view_max_x) <<< 1;
      vmax2_y = BW'(view_max_y) <<< 1;
      floor_ok = !floor_filter_on || (floor_num == floor_select);
      box_ok   = !(lo2_x > vmax2_x) && !(hi2_x < vmin2_x) &&
                 !(lo2_y > vmax2_y) && !(hi2_y < vmin2_y);
      len_ok   = (start_x != end_x) || (start_y != end_y);
      keep     = floor_ok && box_ok && len_ok;
   end

endmodule

// ===== rtl/tsqc_fifo.sv =====
// Two-entry queue between the classifier and the corner sequencer.
// No package dependencies.
module tsqc_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]       cnt_ff, cnt_in;

   always_comb begin
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rp_ff];
   assign full     = cnt_ff[1];
   assign empty    = (cnt_ff == 2'd0);

endmodule

// ===== rtl/tsqc_back.sv =====
// Back-end sequencer: normal offsets through a shared 32x32 multiplier and a
// bit-serial root search, then four corners and the running scene bounds.
// Depends on tsqc_pkg for the segment control struct and widths.
module tsqc_back #(
   parameter int CW = 32,
   parameter int TW = 20
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               seg_valid,
   input  tsqc_pkg::seg_ctl_type              seg_ctl,
   input  logic signed [CW-1:0]               seg_sx,
   input  logic signed [CW-1:0]               seg_sy,
   input  logic signed [CW-1:0]               seg_ex,
   input  logic signed [CW-1:0]               seg_ey,
   input  logic [TW-1:0]                      seg_t,
   input  logic [tsqc_pkg::TAG_WIDTH-1:0]     seg_tag,
   output logic                               seg_pop,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic signed [CW-1:0]               out_x,
   output logic signed [CW-1:0]               out_y,
   output logic [1:0]                         out_index,
   output logic [tsqc_pkg::TAG_WIDTH-1:0]     out_tag,
   output logic                               out_last,
   output logic signed [CW-1:0]               out_min_x,
   output logic signed [CW-1:0]               out_min_y,
   output logic signed [CW-1:0]               out_max_x,
   output logic signed [CW-1:0]               out_max_y
);

   localparam int MW  = tsqc_pkg::MUL_WIDTH;
   localparam int NB  = tsqc_pkg::NORM_BITS;
   localparam int DW  = 2 * NB + 1;
   localparam int NW  = NB + TW;
   localparam int SW  = 2 * NW + 2;
   localparam int BCW = $clog2(TW);
   localparam int EW  = ((CW > TW) ? CW : TW) + 2;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_NORM = 4'd1;
   localparam logic [3:0] S_MA   = 4'd2;
   localparam logic [3:0] S_MB   = 4'd3;
   localparam logic [3:0] S_MC   = 4'd4;
   localparam logic [3:0] S_MD   = 4'd5;
   localparam logic [3:0] S_ME   = 4'd6;
   localparam logic [3:0] S_Q0   = 4'd7;
   localparam logic [3:0] S_Q1   = 4'd8;
   localparam logic [3:0] S_Q2   = 4'd9;
   localparam logic [3:0] S_Q3   = 4'd10;
   localparam logic [3:0] S_ROOT = 4'd11;
   localparam logic [3:0] S_EMIT = 4'd12;

   localparam logic signed [EW-1:0] CMAX = {{(EW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [EW-1:0] CMIN = {{(EW-CW+1){1'b1}}, {(CW-1){1'b0}}};

   logic [3:0] state_ff, state_in;
   logic signed [CW-1:0] sx_ff, sy_ff, ex_ff, ey_ff;
   logic signed [CW-1:0] sx_in, sy_in, ex_in, ey_in;
   logic [TW-1:0] t_ff, t_in;
   logic [tsqc_pkg::TAG_WIDTH-1:0] tag_ff, tag_in;
   logic dxneg_ff, dxneg_in, dyneg_ff, dyneg_in;
   logic [CW:0] ax_ff, ax_in, ay_ff, ay_in;
   logic [DW-1:0] d_ff, d_in;
   logic [NW-1:0] nx_ff, nx_in, ny_ff, ny_in, n_cur;
   logic [2*MW-1:0] prod_ff;
   logic [MW-1:0] mul_a, mul_b;
   logic [SW-1:0] r_ff, r_in, a_ff, a_in, b_ff, b_in, trial;
   logic take;
   logic [TW-1:0] w_ff, w_in, w_step;
   logic [BCW-1:0] bit_ff, bit_in;
   logic [TW-1:0] ox_ff, ox_in, oy_ff, oy_in, rnd;
   logic sel_ff, sel_in;
   logic [1:0] k_ff, k_in;

   logic signed [CW:0] dx, dy;
   logic bounds_valid_ff, bounds_valid_in;
   logic signed [CW-1:0] low_x_ff, low_y_ff, high_x_ff, high_y_ff;
   logic signed [CW-1:0] low_x_in, low_y_in, high_x_in, high_y_in;

   logic out_valid_ff, out_valid_in, load;
   logic signed [CW-1:0] px, py;
   logic signed [EW-1:0] bx, by, rx_e, ry_e, cx, cy;

   logic signed [CW-1:0] ocx_ff, ocy_ff;
   logic [1:0] oidx_ff;
   logic [tsqc_pkg::TAG_WIDTH-1:0] otag_ff;
   logic olast_ff;
   logic signed [CW-1:0] omin_x_ff, omin_y_ff, omax_x_ff, omax_y_ff;

   assign n_cur = sel_ff ? ny_ff : nx_ff;

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MA: begin
            mul_a = MW'(ax_ff);
            mul_b = MW'(ax_ff);
         end
         S_MB: begin
            mul_a = MW'(ay_ff);
            mul_b = MW'(ay_ff);
         end
         S_MC: begin
            mul_a = MW'(ay_ff);
            mul_b = MW'(t_ff);
         end
         S_MD: begin
            mul_a = MW'(ax_ff);
            mul_b = MW'(t_ff);
         end
         S_Q0: begin
            mul_a = n_cur[MW-1:0];
            mul_b = n_cur[MW-1:0];
         end
         S_Q1: begin
            mul_a = MW'(n_cur >> MW);
            mul_b = n_cur[MW-1:0];
         end
         S_Q2: begin
            mul_a = MW'(n_cur >> MW);
            mul_b = MW'(n_cur >> MW);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= (2*MW)'(mul_a) * (2*MW)'(mul_b);
   end

   // One bit of the offset root per cycle: largest w with w*w*d <= n*n.
   always_comb begin
      trial  = a_ff + b_ff;
      take   = (trial <= r_ff);
      w_step = take ? (w_ff | (TW'(1) << bit_ff)) : w_ff;
      rnd    = TW'((({1'b0, w_step}) + (TW+1)'(1)) >> 1);
   end

   // Corner selection and saturation.
   always_comb begin
      bx   = ((k_ff == 2'd0) || (k_ff == 2'd3)) ? EW'(sx_ff) : EW'(ex_ff);
      by   = ((k_ff == 2'd0) || (k_ff == 2'd3)) ? EW'(sy_ff) : EW'(ey_ff);
      rx_e = $signed(EW'(ox_ff));
      ry_e = $signed(EW'(oy_ff));
      if (dyneg_ff) begin
         rx_e = -rx_e;
      end
      if (dxneg_ff) begin
         ry_e = -ry_e;
      end
      if (k_ff[1]) begin
         cx = bx - rx_e;
         cy = by + ry_e;
      end else begin
         cx = bx + rx_e;
         cy = by - ry_e;
      end
      if (cx > CMAX) begin
         px = CW'(CMAX);
      end else if (cx < CMIN) begin
         px = CW'(CMIN);
      end else begin
         px = CW'(cx);
      end
      if (cy > CMAX) begin
         py = CW'(CMAX);
      end else if (cy < CMIN) begin
         py = CW'(CMIN);
      end else begin
         py = CW'(cy);
      end
   end

   assign dx   = $signed({seg_ex[CW-1], seg_ex}) - $signed({seg_sx[CW-1], seg_sx});
   assign dy   = $signed({seg_ey[CW-1], seg_ey}) - $signed({seg_sy[CW-1], seg_sy});
   assign load = (state_ff == S_EMIT) && (!out_valid_ff || out_ready);
   assign seg_pop = (state_ff == S_IDLE) && seg_valid;

   always_comb begin
      state_in = state_ff;
      sx_in = sx_ff; sy_in = sy_ff; ex_in = ex_ff; ey_in = ey_ff;
      t_in = t_ff; tag_in = tag_ff;
      dxneg_in = dxneg_ff; dyneg_in = dyneg_ff;
      ax_in = ax_ff; ay_in = ay_ff;
      d_in = d_ff; nx_in = nx_ff; ny_in = ny_ff;
      r_in = r_ff; a_in = a_ff; b_in = b_ff; w_in = w_ff; bit_in = bit_ff;
      ox_in = ox_ff; oy_in = oy_ff; sel_in = sel_ff; k_in = k_ff;
      bounds_valid_in = bounds_valid_ff;
      low_x_in = low_x_ff; low_y_in = low_y_ff;
      high_x_in = high_x_ff; high_y_in = high_y_ff;
      case (state_ff)
         S_IDLE: begin
            if (seg_valid) begin
               if (seg_ctl.new_scene) begin
                  bounds_valid_in = 1'b0;
                  low_x_in = '0; low_y_in = '0; high_x_in = '0; high_y_in = '0;
               end
               sx_in = seg_sx; sy_in = seg_sy; ex_in = seg_ex; ey_in = seg_ey;
               t_in = seg_t; tag_in = seg_tag;
               dxneg_in = dx[CW];
               dyneg_in = dy[CW];
               ax_in = dx[CW] ? (CW+1)'(-dx) : (CW+1)'(dx);
               ay_in = dy[CW] ? (CW+1)'(-dy) : (CW+1)'(dy);
               if (seg_ctl.keep) begin
                  state_in = S_NORM;
               end
            end
         end
         S_NORM: begin
            // One common right shift per cycle until both fit NORM_BITS.
            if (((ax_ff >> NB) != '0) || ((ay_ff >> NB) != '0)) begin
               ax_in = ax_ff >> 1;
               ay_in = ay_ff >> 1;
            end else begin
               state_in = S_MA;
            end
         end
         S_MA: state_in = S_MB;
         S_MB: begin
            d_in = DW'(prod_ff);
            state_in = S_MC;
         end
         S_MC: begin
            d_in = d_ff + DW'(prod_ff);
            state_in = S_MD;
         end
         S_MD: begin
            nx_in = NW'(prod_ff);
            state_in = S_ME;
         end
         S_ME: begin
            ny_in = NW'(prod_ff);
            sel_in = 1'b0;
            state_in = S_Q0;
         end
         S_Q0: state_in = S_Q1;
         S_Q1: begin
            r_in = SW'(prod_ff);
            state_in = S_Q2;
         end
         S_Q2: begin
            r_in = r_ff + (SW'(prod_ff) << (MW + 1));
            state_in = S_Q3;
         end
         S_Q3: begin
            r_in = r_ff + (SW'(prod_ff) << (2 * MW));
            a_in = '0;
            b_in = SW'(d_ff) << (2 * (TW - 1));
            w_in = '0;
            bit_in = BCW'(TW - 1);
            state_in = S_ROOT;
         end
         S_ROOT: begin
            if (take) begin
               r_in = r_ff - trial;
               a_in = (a_ff >> 1) + b_ff;
            end else begin
               a_in = a_ff >> 1;
            end
            b_in = b_ff >> 2;
            w_in = w_step;
            bit_in = bit_ff - BCW'(1);
            if (bit_ff == '0) begin
               if (sel_ff) begin
                  oy_in = rnd;
                  k_in = 2'd0;
                  state_in = S_EMIT;
               end else begin
                  ox_in = rnd;
                  sel_in = 1'b1;
                  state_in = S_Q0;
               end
            end
         end
         S_EMIT: begin
            if (load) begin
               if (!bounds_valid_ff) begin
                  bounds_valid_in = 1'b1;
                  low_x_in = px; high_x_in = px;
                  low_y_in = py; high_y_in = py;
               end else begin
                  low_x_in  = (px < low_x_ff)  ? px : low_x_ff;
                  low_y_in  = (py < low_y_ff)  ? py : low_y_ff;
                  high_x_in = (px > high_x_ff) ? px : high_x_ff;
                  high_y_in = (py > high_y_ff) ? py : high_y_ff;
               end
               k_in = k_ff + 2'd1;
               if (k_ff == tsqc_pkg::CORNER_LAST) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign out_valid_in = load || (out_valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         bounds_valid_ff <= 1'b0;
         low_x_ff        <= '0;
         low_y_ff        <= '0;
         high_x_ff       <= '0;
         high_y_ff       <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         bounds_valid_ff <= bounds_valid_in;
         low_x_ff        <= low_x_in;
         low_y_ff        <= low_y_in;
         high_x_ff       <= high_x_in;
         high_y_ff       <= high_y_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sx_ff <= sx_in; sy_ff <= sy_in; ex_ff <= ex_in; ey_ff <= ey_in;
      t_ff <= t_in; tag_ff <= tag_in;
      dxneg_ff <= dxneg_in; dyneg_ff <= dyneg_in;
      ax_ff <= ax_in; ay_ff <= ay_in;
      d_ff <= d_in; nx_ff <= nx_in; ny_ff <= ny_in;
      r_ff <= r_in; a_ff <= a_in; b_ff <= b_in; w_ff <= w_in; bit_ff <= bit_in;
      ox_ff <= ox_in; oy_ff <= oy_in; sel_ff <= sel_in; k_ff <= k_in;
      if (load) begin
         ocx_ff    <= px;
         ocy_ff    <= py;
         oidx_ff   <= k_ff;
         otag_ff   <= tag_ff;
         olast_ff  <= (k_ff == tsqc_pkg::CORNER_LAST);
         omin_x_ff <= low_x_in;
         omin_y_ff <= low_y_in;
         omax_x_ff <= high_x_in;
         omax_y_ff <= high_y_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_x     = ocx_ff;
   assign out_y     = ocy_ff;
   assign out_index = oidx_ff;
   assign out_tag   = otag_ff;
   assign out_last  = olast_ff;
   assign out_min_x = omin_x_ff;
   assign out_min_y = omin_y_ff;
   assign out_max_x = omax_x_ff;
   assign out_max_y = omax_y_ff;

   a_bounds_order: assert property (@(posedge clock) disable iff (reset)
      bounds_valid_ff |-> (low_x_ff <= high_x_ff) && (low_y_ff <= high_y_ff))
      else $error("scene bounds out of order");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      seg_pop |-> (state_ff == S_IDLE) && seg_valid)
      else $error("segment popped outside idle");

   a_last_done: assert property (@(posedge clock) disable iff (reset)
      (load && (k_ff == tsqc_pkg::CORNER_LAST)) |=> (state_ff == S_IDLE))
      else $error("sequencer did not finish after the last corner");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load |-> (!out_valid_ff || out_ready))
      else $error("corner loaded over a pending result");

endmodule

// ===== rtl/thick_segment_quad_cull.sv =====
// Top level of the thick segment quad cull block: CSR bank, classifier,
// segment queue and corner sequencer. Depends on tsqc_pkg and all tsqc modules.
//
// Each segment is classified in the cycle it is accepted; kept segments and
// those that start a new scene are queued, and the sequencer then works on
// one segment at a time. A kept segment's time is set by the normalizing
// shift for long segments, by the bit-serial root search, run once for each
// normal component, one result bit per cycle, and by the single shared 32x32
// multiplier. A dropped segment is popped without leaving corners. Four
// corner transfers leave per kept segment, in the order start-n, end-n,
// end+n, start+n, with rsp_tlast on the fourth.
module thick_segment_quad_cull #(
   parameter int COORD_WIDTH = 32,
   parameter int THICK_WIDTH = 20
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // start_x, start_y, end_x, end_y, thickness, floor, wall_tag
   input  logic [((4*COORD_WIDTH+THICK_WIDTH+48+7)/8)*8-1:0] req_tdata,
   // new_scene
   input  logic [0:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // corner_x, corner_y, result_tag, scene_min_x, scene_min_y,
   // scene_max_x, scene_max_y
   output logic [((6*COORD_WIDTH+32+7)/8)*8-1:0] rsp_tdata,
   // corner_index
   output logic [1:0] rsp_tuser,
   // last_corner
   output logic rsp_tlast,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [tsqc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COORD_WIDTH-1:0] csr_wdata
);

   localparam int CW  = COORD_WIDTH;
   localparam int TW  = THICK_WIDTH;
   localparam int FW  = tsqc_pkg::FLOOR_WIDTH;
   localparam int GW  = tsqc_pkg::TAG_WIDTH;
   localparam int QW  = 2 + GW + TW + 4 * CW;
   localparam int OPW = ((6*COORD_WIDTH+32+7)/8)*8;

   logic signed [CW-1:0] view_min_x_ff, view_min_y_ff, view_max_x_ff, view_max_y_ff;
   logic filter_on_ff;
   logic [FW-1:0] floor_sel_ff;

   logic signed [CW-1:0] in_sx, in_sy, in_ex, in_ey;
   logic [TW-1:0] in_t;
   logic [FW-1:0] in_floor;
   logic [GW-1:0] in_tag;
   logic keep;
   tsqc_pkg::seg_ctl_type in_ctl, q_ctl;
   logic q_push, q_pop, q_full, q_empty;
   logic [QW-1:0] q_pop_data;
   logic signed [CW-1:0] q_sx, q_sy, q_ex, q_ey;
   logic [TW-1:0] q_t;
   logic [GW-1:0] q_tag;

   logic signed [CW-1:0] o_x, o_y, o_min_x, o_min_y, o_max_x, o_max_y;
   logic [GW-1:0] o_tag;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         view_min_x_ff <= {1'b1, {(CW-1){1'b0}}};
         view_min_y_ff <= {1'b1, {(CW-1){1'b0}}};
         view_max_x_ff <= {1'b0, {(CW-1){1'b1}}};
         view_max_y_ff <= {1'b0, {(CW-1){1'b1}}};
         filter_on_ff  <= 1'b0;
         floor_sel_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            tsqc_pkg::CSR_VIEW_MIN_X:   view_min_x_ff <= csr_wdata;
            tsqc_pkg::CSR_VIEW_MIN_Y:   view_min_y_ff <= csr_wdata;
            tsqc_pkg::CSR_VIEW_MAX_X:   view_max_x_ff <= csr_wdata;
            tsqc_pkg::CSR_VIEW_MAX_Y:   view_max_y_ff <= csr_wdata;
            tsqc_pkg::CSR_FLOOR_FILTER: filter_on_ff  <= csr_wdata[0];
            tsqc_pkg::CSR_FLOOR_SELECT: floor_sel_ff  <= csr_wdata[FW-1:0];
            default: ;
         endcase
      end
   end

   assign in_sx    = req_tdata[CW-1:0];
   assign in_sy    = req_tdata[2*CW-1:CW];
   assign in_ex    = req_tdata[3*CW-1:2*CW];
   assign in_ey    = req_tdata[4*CW-1:3*CW];
   assign in_t     = req_tdata[4*CW+TW-1:4*CW];
   assign in_floor = req_tdata[4*CW+TW+FW-1:4*CW+TW];
   assign in_tag   = req_tdata[4*CW+TW+FW+GW-1:4*CW+TW+FW];

   tsqc_front #(.CW(CW), .TW(TW)) u_front (
      .start_x         (in_sx),
      .start_y         (in_sy),
      .end_x           (in_ex),
      .end_y           (in_ey),
      .thickness       (in_t),
      .floor_num       (in_floor),
      .view_min_x      (view_min_x_ff),
      .view_min_y      (view_min_y_ff),
      .view_max_x      (view_max_x_ff),
      .view_max_y      (view_max_y_ff),
      .floor_filter_on (filter_on_ff),
      .floor_select    (floor_sel_ff),
      .keep            (keep)
   );

   assign in_ctl.new_scene = req_tuser[0];
   assign in_ctl.keep      = keep;
   assign req_tready = !q_full;
   // A dropped segment still travels when it clears the scene bounds.
   assign q_push = req_tvalid && req_tready && (keep || req_tuser[0]);

   tsqc_fifo #(.WIDTH(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({in_ctl, in_tag, in_t, in_ey, in_ex, in_sy, in_sx}),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   assign {q_ctl, q_tag, q_t, q_ey, q_ex, q_sy, q_sx} = q_pop_data;

   tsqc_back #(.CW(CW), .TW(TW)) u_back (
      .clock     (clock),
      .reset     (reset),
      .seg_valid (!q_empty),
      .seg_ctl   (q_ctl),
      .seg_sx    (q_sx),
      .seg_sy    (q_sy),
      .seg_ex    (q_ex),
      .seg_ey    (q_ey),
      .seg_t     (q_t),
      .seg_tag   (q_tag),
      .seg_pop   (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_x     (o_x),
      .out_y     (o_y),
      .out_index (rsp_tuser),
      .out_tag   (o_tag),
      .out_last  (rsp_tlast),
      .out_min_x (o_min_x),
      .out_min_y (o_min_y),
      .out_max_x (o_max_x),
      .out_max_y (o_max_y)
   );

   assign rsp_tdata = OPW'({o_max_y, o_max_x, o_min_y, o_min_x, o_tag, o_y, o_x});

endmodule
